[sv/tkpo_pkg.sv]
// Shared types and constants for the time keyed permutation order block.
// Used by every module of the block but tkpo_div_cell; depends on nothing.
`default_nettype none

package tkpo_pkg;

   localparam int unsigned DATA_W        = 32;
   localparam int unsigned IDX_W         = 16;
   localparam int unsigned ORDER_W       = 40;
   localparam int unsigned NIB_W         = 4;
   localparam int unsigned NUM_FUNCS_DEF = 10;
   localparam int unsigned PERIOD_DEF    = 40320;

   localparam logic [DATA_W-1:0] EPOCH_RST = 32'd1492973331;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_DIV,
      ST_PERM,
      ST_DONE
   } state_type;

   // load / step controls for the sequential units
   typedef struct packed {
      logic load;
      logic step;
   } unit_ctrl_type;

endpackage

`default_nettype wire

[sv/tkpo_mod_unit.sv]
// Reduction of the 32-bit time difference modulo PERIOD by reciprocal
// multiplication. Depends on tkpo_pkg.
`default_nettype none

module tkpo_mod_unit #(
   parameter int unsigned PERIOD = tkpo_pkg::PERIOD_DEF,
   parameter int unsigned RW     = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tkpo_pkg::unit_ctrl_type       ctrl,
   input  wire logic [tkpo_pkg::DATA_W-1:0]   diff,
   output logic      [RW-1:0]                 rank
);

   localparam int unsigned DW = tkpo_pkg::DATA_W;
   // floor(x / PERIOD) = (x * RECIP) >> SH, exact for every 32-bit x
   localparam int unsigned SH = DW + RW;
   localparam int unsigned PW = SH + DW;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(PERIOD) - 64'd1) / 64'(PERIOD);

   logic [DW-1:0] x_ff, x_in;
   logic [DW-1:0] q_ff, q_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [PW-1:0] prod;
   logic [DW-1:0] qp;

   // first step forms the quotient, second the remainder
   always_comb begin
      prod   = PW'(x_ff) * PW'(RECIP);
      qp     = q_ff * DW'(PERIOD);
      x_in   = x_ff;
      q_in   = q_ff;
      rem_in = rem_ff;
      if (ctrl.load) begin
         x_in = diff;
      end else if (ctrl.step) begin
         q_in   = prod[SH +: DW];
         rem_in = RW'(x_ff - qp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      q_ff <= q_in;
   end

   assign rank = rem_ff;

endmodule

`default_nettype wire

[sv/tkpo_div_cell.sv]
// One cell of the factoradic chain: divides the value from its neighbour by
// a small constant, passes the quotient on and keeps the remainder.
// Depends on no other file.
`default_nettype none

module tkpo_div_cell #(
   parameter int unsigned DIVISOR = 2,
   parameter int unsigned VW      = 16,
   parameter int unsigned DW      = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [VW-1:0] in_value,
   output logic               out_valid,
   output logic [VW-1:0]      out_value,
   output logic [DW-1:0]      rem
);

   // v / DIVISOR = (v * RECIP) >> SH, exact for every VW-bit v, DIVISOR up to 32
   localparam int unsigned SH = VW + 5;
   localparam int unsigned PW = SH + VW;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

   logic [PW-1:0] prod;
   logic [VW-1:0] quot, back;
   logic          valid_ff;
   logic [VW-1:0] value_ff;
   logic [DW-1:0] rem_ff, rem_in;

   always_comb begin
      prod   = PW'(in_value) * PW'(RECIP);
      quot   = prod[SH +: VW];
      back   = quot * VW'(DIVISOR);
      rem_in = in_valid ? DW'(in_value - back) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= quot;
      rem_ff   <= rem_in;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign rem       = rem_ff;

endmodule

`default_nettype wire

[sv/tkpo_perm_unit.sv]
// Turns Lehmer digits into the permutation, one position a cycle while step is
// high, by picking from a shrinking list of unused indices. Depends on tkpo_pkg.
`default_nettype none

module tkpo_perm_unit #(
   parameter int unsigned NUM_FUNCS = tkpo_pkg::NUM_FUNCS_DEF,
   parameter int unsigned IW        = 4
) (
   input  wire logic                                  clock,
   input  wire tkpo_pkg::unit_ctrl_type               ctrl,
   input  wire logic [NUM_FUNCS-1:0][IW-1:0]          digits,
   output logic      [NUM_FUNCS*tkpo_pkg::NIB_W-1:0]  order
);

   localparam int unsigned NW = tkpo_pkg::NIB_W;
   localparam int unsigned OW = NUM_FUNCS * NW;

   logic [NUM_FUNCS-1:0][IW-1:0] lehmer_ff, lehmer_in;
   logic [NUM_FUNCS-1:0][IW-1:0] avail_ff, avail_in;
   logic [OW-1:0]                order_ff, order_in;
   logic [IW-1:0]                sel;

   always_comb begin
      sel       = lehmer_ff[0];
      lehmer_in = lehmer_ff;
      avail_in  = avail_ff;
      order_in  = order_ff;
      if (ctrl.load) begin
         lehmer_in = digits;
         for (int k = 0; k < NUM_FUNCS; k++) begin
            avail_in[k] = IW'(k);
         end
      end else if (ctrl.step) begin
         lehmer_in = lehmer_ff >> IW;
         // drop the chosen entry, close the gap
         for (int k = 0; k < NUM_FUNCS - 1; k++) begin
            if (IW'(k) >= sel) begin
               avail_in[k] = avail_ff[k+1];
            end
         end
         order_in = {NW'(avail_ff[sel]), order_ff[OW-1:NW]};
      end
   end

   always_ff @(posedge clock) begin
      lehmer_ff <= lehmer_in;
      avail_ff  <= avail_in;
      order_ff  <= order_in;
   end

   assign order = order_ff;

endmodule

`default_nettype wire

[sv/time_keyed_permutation_order.sv]
// Time keyed permutation order: top level.
// Depends on tkpo_pkg, tkpo_mod_unit, tkpo_div_cell and tkpo_perm_unit.
//
// Usage: drive req_time_value and raise start while busy is low; the
// transaction is taken at that edge. One result follows per transaction:
// rsp_strobe is high for exactly one cycle with rsp_step_index, the rank
// (time - epoch) mod PERIOD, and rsp_order, the rank-th lexicographic
// permutation of 0..NUM_FUNCS-1, one nibble per position, position 0 low.
// The receiver cannot stall; the result holds until the next transaction.
// Steps: reciprocal reduction in ST_MOD, then the rank steps through the
// chain of divide cells in ST_DIV, one cell a cycle, then the permutation
// build in ST_PERM; rsp_strobe is high in ST_DONE. busy drops after it,
// so a new transaction is taken only once the last is through. The epoch
// is written over the csr_ channel, always ready; the time difference
// is latched on acceptance. Reset returns to idle and loads the default
// epoch.
`default_nettype none

module time_keyed_permutation_order #(
   parameter int unsigned NUM_FUNCS = tkpo_pkg::NUM_FUNCS_DEF,
   parameter int unsigned PERIOD    = tkpo_pkg::PERIOD_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [tkpo_pkg::DATA_W-1:0]   req_time_value,
   output logic                               rsp_strobe,
   output logic      [tkpo_pkg::IDX_W-1:0]    rsp_step_index,
   output logic      [tkpo_pkg::ORDER_W-1:0]  rsp_order,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [tkpo_pkg::DATA_W-1:0]   csr_epoch
);

   localparam int unsigned DW       = tkpo_pkg::DATA_W;
   localparam int unsigned XW       = tkpo_pkg::IDX_W;
   localparam int unsigned ORD_W    = tkpo_pkg::ORDER_W;
   localparam int unsigned NW       = tkpo_pkg::NIB_W;
   localparam int unsigned RW       = (PERIOD > 1) ? $clog2(PERIOD) : 1;
   localparam int unsigned IW       = $clog2(NUM_FUNCS);
   localparam int unsigned MOD_LAST = 1;
   localparam int unsigned DIV_LAST = NUM_FUNCS - 2;
   localparam int unsigned PERM_LAST = NUM_FUNCS;
   localparam int unsigned CNT_TOP  = (MOD_LAST > DIV_LAST) ?
                                      ((MOD_LAST > PERM_LAST) ? MOD_LAST : PERM_LAST) :
                                      ((DIV_LAST > PERM_LAST) ? DIV_LAST : PERM_LAST);
   localparam int unsigned CW       = $clog2(CNT_TOP + 1);

   tkpo_pkg::state_type     state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [DW-1:0]           base_ff;
   logic [RW-1:0]           rank;
   logic [DW-1:0]           diff;
   tkpo_pkg::unit_ctrl_type mod_ctrl, perm_ctrl;
   wire logic [NUM_FUNCS-1:0]         link_valid;
   wire logic [NUM_FUNCS-1:0][RW-1:0] link_value;
   logic [NUM_FUNCS-1:0][IW-1:0] digits;
   logic [NUM_FUNCS*NW-1:0] order;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= tkpo_pkg::EPOCH_RST;
      end else if (csr_valid && csr_ready) begin
         base_ff <= csr_epoch;
      end
   end

   assign csr_ready = 1'b1;
   assign diff      = req_time_value - base_ff;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      mod_ctrl   = '0;
      perm_ctrl  = '0;
      unique case (state_ff)
         tkpo_pkg::ST_IDLE: begin
            if (start) begin
               mod_ctrl.load = 1'b1;
               cnt_in        = '0;
               state_in      = tkpo_pkg::ST_MOD;
            end
         end
         tkpo_pkg::ST_MOD: begin
            mod_ctrl.step = 1'b1;
            if (cnt_ff == CW'(MOD_LAST)) begin
               cnt_in   = '0;
               state_in = tkpo_pkg::ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tkpo_pkg::ST_DIV: begin
            // rank enters the chain while the count is zero, then moves on one cell a cycle
            if (cnt_ff == CW'(DIV_LAST)) begin
               cnt_in   = '0;
               state_in = tkpo_pkg::ST_PERM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tkpo_pkg::ST_PERM: begin
            perm_ctrl.load = (cnt_ff == '0);
            perm_ctrl.step = (cnt_ff != '0);
            if (cnt_ff == CW'(PERM_LAST)) begin
               cnt_in   = '0;
               state_in = tkpo_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tkpo_pkg::ST_DONE: begin
            state_in = tkpo_pkg::ST_IDLE;
         end
         default: begin
            state_in = tkpo_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkpo_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   tkpo_mod_unit #(
      .PERIOD (PERIOD),
      .RW     (RW)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .ctrl  (mod_ctrl),
      .diff  (diff),
      .rank  (rank)
   );

   assign link_valid[0] = (state_ff == tkpo_pkg::ST_DIV) && (cnt_ff == '0);
   assign link_value[0] = rank;

   // cell j divides by j+2; its remainder is the Lehmer digit of
   // position NUM_FUNCS-2-j. The last position always takes digit 0.
   for (genvar j = 0; j < NUM_FUNCS - 1; j++) begin : g_cell
      tkpo_div_cell #(
         .DIVISOR (j + 2),
         .VW      (RW),
         .DW      (IW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[j]),
         .in_value  (link_value[j]),
         .out_valid (link_valid[j+1]),
         .out_value (link_value[j+1]),
         .rem       (digits[NUM_FUNCS-2-j])
      );
   end

   assign digits[NUM_FUNCS-1] = '0;

   tkpo_perm_unit #(
      .NUM_FUNCS (NUM_FUNCS),
      .IW        (IW)
   ) u_perm (
      .clock  (clock),
      .ctrl   (perm_ctrl),
      .digits (digits),
      .order  (order)
   );

   assign busy           = (state_ff != tkpo_pkg::ST_IDLE);
   assign rsp_strobe     = (state_ff == tkpo_pkg::ST_DONE);
   assign rsp_step_index = XW'(rank);
   assign rsp_order      = ORD_W'(order);

   a_accept_starts_mod : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == tkpo_pkg::ST_MOD))
      else $error("accepted transaction did not start the reduction");

   a_single_result : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result strobe held or block stayed busy after result");

   a_rank_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((PERIOD > 65536) || (int'(rsp_step_index) < int'(PERIOD))))
      else $error("rank not below the period");

endmodule

`default_nettype wire

[tb/tb_time_keyed_permutation_order.sv]
// Testbench for time_keyed_permutation_order: drives block times and epoch
// writes, predicts the rank and its lexicographic order, checks every result strobe.
// Depends on tkpo_pkg and the time_keyed_permutation_order RTL.
module tb_time_keyed_permutation_order;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned TAIL_CYCLES    = 100;
   localparam int unsigned PHASES         = 10;
   localparam int unsigned PHASE_ITEMS    = 150;

   typedef enum logic [1:0] {
      JOB_TIME,
      JOB_BASE,
      JOB_SETTLE
   } job_kind_type;

   typedef struct {
      job_kind_type                kind;
      logic [tkpo_pkg::DATA_W-1:0] value;
      int unsigned                 gap;
   } job_type;

   typedef struct {
      logic [tkpo_pkg::IDX_W-1:0]   step;
      logic [tkpo_pkg::ORDER_W-1:0] order;
   } order_due_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          start          = 1'b0;
   logic                          busy;
   logic [tkpo_pkg::DATA_W-1:0]   req_time_value = '0;
   logic                          rsp_strobe;
   logic [tkpo_pkg::IDX_W-1:0]    rsp_step_index;
   logic [tkpo_pkg::ORDER_W-1:0]  rsp_order;
   logic                          csr_valid      = 1'b0;
   logic                          csr_ready;
   logic [tkpo_pkg::DATA_W-1:0]   csr_epoch      = '0;

   job_type                       job_q[$];
   order_due_type                 order_due_q[$];
   logic [tkpo_pkg::DATA_W-1:0]   model_base;
   int                            gap_left;
   int unsigned                   mismatch_count = 0;
   int unsigned                   idle_cycles    = 0;

   time_keyed_permutation_order #(
      .NUM_FUNCS (tkpo_pkg::NUM_FUNCS_DEF),
      .PERIOD    (tkpo_pkg::PERIOD_DEF)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_time_value (req_time_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_step_index (rsp_step_index),
      .rsp_order      (rsp_order),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_epoch      (csr_epoch)
   );

   always #5 clock = ~clock;

   // rank from the wrapped time difference, then unranking in the factorial
   // number system: each digit picks one of the indices still unused
   function automatic order_due_type predict_order(logic [tkpo_pkg::DATA_W-1:0] t,
                                                   logic [tkpo_pkg::DATA_W-1:0] base);
      int unsigned                 pool [16];
      int unsigned                 left, rem, radix, pick;
      logic [tkpo_pkg::DATA_W-1:0] delta;
      order_due_type               due;
      delta     = t - base;
      rem       = delta % tkpo_pkg::PERIOD_DEF;
      due.step  = tkpo_pkg::IDX_W'(rem);
      due.order = '0;
      radix     = 1;
      for (int unsigned k = 0; k < 16; k++) pool[k] = k;
      for (int unsigned k = 2; k <= tkpo_pkg::NUM_FUNCS_DEF; k++) radix *= k;
      rem  = rem % radix;
      left = tkpo_pkg::NUM_FUNCS_DEF;
      for (int unsigned pos = 0; pos < tkpo_pkg::NUM_FUNCS_DEF && pos < 10; pos++) begin
         radix = radix / left;
         pick  = rem / radix;
         rem   = rem % radix;
         due.order[tkpo_pkg::NIB_W*pos +: tkpo_pkg::NIB_W] = tkpo_pkg::NIB_W'(pool[pick]);
         for (int unsigned k = pick; k + 1 < left; k++) pool[k] = pool[k+1];
         left--;
      end
      return due;
   endfunction

   function automatic int unsigned pick_gap(bit steady);
      int unsigned roll;
      if (steady) return 0;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(160, 20);
   endfunction

   function automatic logic [tkpo_pkg::DATA_W-1:0] pick_time(
         logic [tkpo_pkg::DATA_W-1:0] base);
      logic [tkpo_pkg::DATA_W-1:0] wraps;
      wraps = tkpo_pkg::DATA_W'(tkpo_pkg::PERIOD_DEF) *
              tkpo_pkg::DATA_W'($urandom_range(100000));
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return base + tkpo_pkg::DATA_W'($urandom_range(tkpo_pkg::PERIOD_DEF - 1));
         // ranks near either end of the period
         2:       return base + wraps + ($urandom_range(1) ?
                     tkpo_pkg::DATA_W'($urandom_range(3)) :
                     tkpo_pkg::DATA_W'(tkpo_pkg::PERIOD_DEF - 1 - $urandom_range(3)));
         // time before base
         default: return base - tkpo_pkg::DATA_W'($urandom_range(4 * tkpo_pkg::PERIOD_DEF, 1));
      endcase
   endfunction

   function automatic void queue_job(job_kind_type kind, logic [tkpo_pkg::DATA_W-1:0] value,
                                     int unsigned gap);
      job_type j;
      j.kind  = kind;
      j.value = value;
      j.gap   = gap;
      job_q.push_back(j);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // driver: one job at a time; base writes and settles wait for an idle block
   always @(posedge clock) begin : drive_jobs
      logic    nxt_start, nxt_csr_valid;
      job_type head;
      nxt_start     = start;
      nxt_csr_valid = csr_valid;
      if (reset) begin
         nxt_start     = 1'b0;
         nxt_csr_valid = 1'b0;
         model_base    = tkpo_pkg::EPOCH_RST;
         gap_left      = -1;
      end else begin
         if (start && !busy) begin
            order_due_q.push_back(predict_order(req_time_value, model_base));
            nxt_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            model_base    = csr_epoch;
            nxt_csr_valid = 1'b0;
         end
         if (!nxt_start && !nxt_csr_valid && job_q.size() != 0) begin
            head = job_q[0];
            if (gap_left < 0) gap_left = head.gap;
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               case (head.kind)
                  JOB_TIME: begin
                     req_time_value <= head.value;
                     nxt_start = 1'b1;
                     void'(job_q.pop_front());
                     gap_left = -1;
                  end
                  JOB_BASE: begin
                     if (order_due_q.size() == 0 && !busy) begin
                        csr_epoch <= head.value;
                        nxt_csr_valid = 1'b1;
                        void'(job_q.pop_front());
                        gap_left = -1;
                     end
                  end
                  default: begin
                     if (order_due_q.size() == 0 && !busy) begin
                        void'(job_q.pop_front());
                        gap_left = -1;
                     end
                  end
               endcase
            end
         end
      end
      start     <= nxt_start;
      csr_valid <= nxt_csr_valid;
   end

   always @(posedge clock) begin : watch_results
      order_due_type due;
      if (!reset && rsp_strobe) begin
         if (order_due_q.size() == 0) begin
            report_mismatch("result with none outstanding", rsp_order, '0);
         end else begin
            due = order_due_q.pop_front();
            if (rsp_step_index !== due.step)
               report_mismatch("step_index", rsp_step_index, due.step);
            if (rsp_order !== due.order)
               report_mismatch("order", rsp_order, due.order);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [tkpo_pkg::DATA_W-1:0] base;
      bit                          steady;
      // directed: reset base first
      base = tkpo_pkg::EPOCH_RST;
      queue_job(JOB_TIME, base, 0);
      queue_job(JOB_TIME, base + 1, 0);
      queue_job(JOB_TIME, base + tkpo_pkg::PERIOD_DEF - 1, 0);
      queue_job(JOB_TIME, base + tkpo_pkg::PERIOD_DEF, 0);
      queue_job(JOB_TIME, base - 1, 0);
      queue_job(JOB_TIME, base + 5039, 0);
      queue_job(JOB_TIME, base + 5040, 40);
      queue_job(JOB_TIME, '0, 0);
      queue_job(JOB_TIME, '1, 0);
      queue_job(JOB_TIME, 32'hAAAA_AAAA, 0);
      queue_job(JOB_TIME, 32'h5555_5555, 0);
      queue_job(JOB_SETTLE, '0, 0);
      queue_job(JOB_BASE, '0, 0);
      queue_job(JOB_TIME, '0, 0);
      queue_job(JOB_TIME, tkpo_pkg::PERIOD_DEF - 1, 0);
      queue_job(JOB_TIME, tkpo_pkg::PERIOD_DEF, 0);
      queue_job(JOB_TIME, 1, 0);
      queue_job(JOB_TIME, '1, 0);
      queue_job(JOB_SETTLE, '0, 0);
      queue_job(JOB_BASE, '1, 0);
      queue_job(JOB_TIME, '0, 0);
      queue_job(JOB_TIME, 32'hFFFF_FFFE, 0);
      queue_job(JOB_TIME, '1, 0);
      queue_job(JOB_TIME, 32'h8000_0000, 0);

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       base = '0;
            1:       base = '1;
            2:       base = tkpo_pkg::EPOCH_RST;
            default: base = $urandom();
         endcase
         steady = (phase % 3 == 1);
         queue_job(JOB_SETTLE, '0, pick_gap(1'b0));
         queue_job(JOB_BASE, base, pick_gap(steady));
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) == 0) queue_job(JOB_SETTLE, '0, 0);
            queue_job(JOB_TIME, pick_time(base), pick_gap(steady));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // sampled mid-cycle so the driver's updates at the edge have settled
      while (job_q.size() != 0 || start || csr_valid || order_due_q.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
sv/tkpo_pkg.sv
sv/tkpo_mod_unit.sv
sv/tkpo_div_cell.sv
sv/tkpo_perm_unit.sv
sv/time_keyed_permutation_order.sv
tb/tb_time_keyed_permutation_order.sv
